/* rtl/pngenc_pkg.sv */
package pngenc_pkg;

   localparam int unsigned MaxWidth  = 8192;
   localparam int unsigned MaxHeight = 8192;
   localparam logic [16:0] AdlerMod  = 17'd65521;
   localparam logic [31:0] CrcPoly   = 32'hEDB88320;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   // An emitted byte and whether it feeds the CRC.
   typedef struct packed {
      logic [7:0] data;
      logic       with_crc;
   } byte_type;

   // Controls from the sequencer to the checksum unit.
   typedef struct packed {
      logic       crc_init;
      logic       crc_byte;
      logic [7:0] crc_data;
      logic       adl_init;
      logic       adl_byte;
      logic [7:0] adl_data;
   } sum_ctl_type;

   // Status from the checksum unit.
   typedef struct packed {
      logic        busy;
      logic [31:0] crc;
      logic [31:0] adler;
   } sum_sts_type;

   function automatic logic [7:0] signature_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h89;
         3'd1: b = 8'h50;
         3'd2: b = 8'h4e;
         3'd3: b = 8'h47;
         3'd4: b = 8'h0d;
         3'd5: b = 8'h0a;
         3'd6: b = 8'h1a;
         default: b = 8'h0a;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] iend_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd4: b = 8'h49;
         4'd5: b = 8'h45;
         4'd6: b = 8'h4e;
         4'd7: b = 8'h44;
         4'd8: b = 8'hae;
         4'd9: b = 8'h42;
         4'd10: b = 8'h60;
         4'd11: b = 8'h82;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* rtl/png_stored_rgb_encoder_unit.sv */
// Streams an 8-bit RGB image in and a complete uncompressed PNG file out.
// Requests on req_ carry one color sample each: red, green, blue per pixel,
// row by row. Each request produces a burst of bytes on rsp_: the first
// request of an image first yields signature, IHDR, IDAT header and zlib
// header; the first sample of a row yields the stored block header and
// filter byte; the last sample yields Adler-32, IDAT CRC and IEND.
// rsp_run_last marks the final byte of a request's burst and rsp_file_end
// the last byte of the file.
// One request is worked on at a time. Every byte that feeds the CRC goes
// through a shared bit-serial CRC unit. The 32-bit IDAT length is formed
// by shift-and-add on the same sequencer.
// csr_ writes set width (index 0) and height (index 1); they are ignored
// while an image is in progress. Reset returns to the file-not-started
// state with width and height of one. A stalled rsp_ holds its byte and
// the sequencer waits.
module png_stored_rgb_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_file_end,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_EMIT = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // Byte phases of a burst.
   localparam logic [2:0] PH_HEAD = 3'd0;
   localparam logic [2:0] PH_ROW  = 3'd1;
   localparam logic [2:0] PH_PIX  = 3'd2;
   localparam logic [2:0] PH_TAIL = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  idx_ff, idx_in;
   logic [13:0] width_reg_ff, width_reg_in;
   logic [13:0] height_reg_ff, height_reg_in;
   logic [13:0] w_ff, w_in;
   logic [13:0] h_ff, h_in;
   logic [12:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [1:0]  comp_ff, comp_in;
   logic        started_ff, started_in;
   logic [7:0]  sample_ff, sample_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] crc_hold_ff, crc_hold_in;
   logic [4:0]  mcnt_ff, mcnt_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;
   logic        oend_ff, oend_in;
   logic        ovalid_ff, ovalid_in;

   pngenc_pkg::sum_ctl_type ctl;
   pngenc_pkg::sum_sts_type sts;
   pngenc_pkg::byte_type    cur;

   pngenc_sum u_sum (.clock(clock), .reset(reset), .ctl(ctl), .sts(sts));

   logic [13:0] w_clamp, h_clamp;
   logic [15:0] blen;
   logic        head_done, row_done, tail_done;

   always_comb begin
      w_clamp = (width_reg_ff == 14'd0) ? 14'd1 :
                (width_reg_ff > 14'(pngenc_pkg::MaxWidth)) ?
                14'(pngenc_pkg::MaxWidth) : width_reg_ff;
      h_clamp = (height_reg_ff == 14'd0) ? 14'd1 :
                (height_reg_ff > 14'(pngenc_pkg::MaxHeight)) ?
                14'(pngenc_pkg::MaxHeight) : height_reg_ff;
      blen = 16'({w_ff, 1'b0} + {2'd0, w_ff}) + 16'd1;
   end

   // Current byte of the burst and whether it feeds the CRC.
   always_comb begin
      cur = '{data: 8'h00, with_crc: 1'b0};
      case (phase_ff)
         PH_HEAD: begin
            if (idx_ff < 6'd8) begin
               cur.data = pngenc_pkg::signature_byte(idx_ff[2:0]);
            end else if (idx_ff < 6'd12) begin
               cur.data = (idx_ff == 6'd11) ? 8'd13 : 8'd0;
            end else if (idx_ff < 6'd29) begin
               cur.with_crc = 1'b1;
               case (idx_ff)
                  6'd12: cur.data = 8'h49;
                  6'd13: cur.data = 8'h48;
                  6'd14: cur.data = 8'h44;
                  6'd15: cur.data = 8'h52;
                  6'd18: cur.data = {2'd0, w_ff[13:8]};
                  6'd19: cur.data = w_ff[7:0];
                  6'd22: cur.data = {2'd0, h_ff[13:8]};
                  6'd23: cur.data = h_ff[7:0];
                  6'd24: cur.data = 8'h08;
                  6'd25: cur.data = 8'h02;
                  default: cur.data = 8'h00;
               endcase
            end else if (idx_ff < 6'd33) begin
               cur.data = crc_hold_ff[8'(6'd32 - idx_ff) * 8 +: 8];
            end else if (idx_ff < 6'd37) begin
               cur.data = len_ff[8'(6'd36 - idx_ff) * 8 +: 8];
            end else begin
               cur.with_crc = 1'b1;
               case (idx_ff)
                  6'd37: cur.data = 8'h49;
                  6'd38: cur.data = 8'h44;
                  6'd39: cur.data = 8'h41;
                  6'd40: cur.data = 8'h54;
                  6'd41: cur.data = 8'h78;
                  default: cur.data = 8'h01;
               endcase
            end
         end
         PH_ROW: begin
            cur.with_crc = 1'b1;
            case (idx_ff[2:0])
               3'd0: cur.data = {7'd0, (14'({1'b0, row_ff}) + 14'd1 == h_ff)};
               3'd1: cur.data = blen[7:0];
               3'd2: cur.data = blen[15:8];
               3'd3: cur.data = ~blen[7:0];
               3'd4: cur.data = ~blen[15:8];
               default: cur.data = 8'h00;
            endcase
         end
         PH_PIX: begin
            cur = '{data: sample_ff, with_crc: 1'b1};
         end
         default: begin
            if (idx_ff < 6'd4) begin
               cur.with_crc = 1'b1;
               cur.data = sts.adler[8'(6'd3 - idx_ff) * 8 +: 8];
            end else if (idx_ff < 6'd8) begin
               cur.data = crc_hold_ff[8'(6'd7 - idx_ff) * 8 +: 8];
            end else begin
               cur.data = pngenc_pkg::iend_byte(4'(idx_ff - 6'd8));
            end
         end
      endcase
   end

   assign head_done = (idx_ff == 6'd42);
   assign row_done  = (idx_ff == 6'd5);
   assign tail_done = (idx_ff == 6'd19);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      width_reg_in = width_reg_ff;
      height_reg_in = height_reg_ff;
      w_in = w_ff;
      h_in = h_ff;
      col_in = col_ff;
      row_in = row_ff;
      comp_in = comp_ff;
      started_in = started_ff;
      sample_in = sample_ff;
      len_in = len_ff;
      crc_hold_in = crc_hold_ff;
      mcnt_in = mcnt_ff;
      mcand_in = mcand_ff;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      oend_in = oend_ff;
      ovalid_in = ovalid_ff;
      ctl = '0;

      if (ovalid_ff && !rsp_stall) begin
         ovalid_in = 1'b0;
      end

      if (csr_write && !started_ff) begin
         unique case (csr_index)
            pngenc_pkg::CSR_WIDTH:  width_reg_in = csr_data;
            pngenc_pkg::CSR_HEIGHT: height_reg_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               idx_in = 6'd0;
               if (!started_ff) begin
                  w_in = w_clamp;
                  h_in = h_clamp;
                  started_in = 1'b1;
                  phase_in = PH_HEAD;
                  // idat_len = h * (3w + 6) + 6, built by shift-and-add over h.
                  len_in = 32'd6;
                  mcand_in = 32'({w_clamp, 1'b0} + {2'd0, w_clamp}) + 32'd6;
                  mcnt_in = 5'd0;
                  state_in = ST_LEN;
               end else begin
                  phase_in = (comp_ff == 2'd0 && col_ff == 13'd0) ? PH_ROW : PH_PIX;
                  if (comp_ff == 2'd0 && col_ff == 13'd0) begin
                     ctl.adl_byte = 1'b1;
                     ctl.adl_data = 8'h00;
                  end
                  state_in = ST_WAIT;
               end
            end
         end
         ST_LEN: begin
            if (h_ff[mcnt_ff[3:0]]) begin
               len_in = len_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[30:0], 1'b0};
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd13) begin
               ctl.adl_init = 1'b1;
               ctl.adl_byte = 1'b0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // Hold until the checksum unit has digested the previous byte.
            if (!sts.busy) begin
               // The IHDR CRC is complete once its last byte is folded in.
               if (phase_ff == PH_HEAD && idx_ff == 6'd29) begin
                  crc_hold_in = sts.crc;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ovalid_ff || !rsp_stall) begin
               ovalid_in = 1'b1;
               obyte_in = cur.data;
               olast_in = 1'b0;
               oend_in = 1'b0;
               ctl.crc_byte = cur.with_crc;
               ctl.crc_data = cur.data;
               // The byte ahead of each chunk type does not feed the CRC, so the
               // CRC can restart alongside it.
               if (phase_ff == PH_HEAD && (idx_ff == 6'd11 || idx_ff == 6'd36)) begin
                  ctl.crc_init = 1'b1;
               end
               idx_in = idx_ff + 6'd1;
               state_in = ST_WAIT;
               case (phase_ff)
                  PH_HEAD: begin
                     if (head_done) begin
                        idx_in = 6'd0;
                        phase_in = (comp_ff == 2'd0 && col_ff == 13'd0) ?
                                   PH_ROW : PH_PIX;
                        if (comp_ff == 2'd0 && col_ff == 13'd0) begin
                           ctl.adl_byte = 1'b1;
                           ctl.adl_data = 8'h00;
                        end
                     end
                  end
                  PH_ROW: begin
                     if (row_done) begin
                        idx_in = 6'd0;
                        phase_in = PH_PIX;
                     end
                  end
                  PH_PIX: begin
                     ctl.adl_byte = 1'b1;
                     ctl.adl_data = sample_ff;
                     if (comp_ff == 2'd2) begin
                        comp_in = 2'd0;
                        if (14'({1'b0, col_ff}) + 14'd1 >= w_ff) begin
                           col_in = 13'd0;
                           if (14'({1'b0, row_ff}) + 14'd1 < h_ff) begin
                              row_in = row_ff + 13'd1;
                           end
                        end else begin
                           col_in = col_ff + 13'd1;
                        end
                     end else begin
                        comp_in = comp_ff + 2'd1;
                     end
                     if (comp_ff == 2'd2 && 14'({1'b0, col_ff}) + 14'd1 >= w_ff &&
                         14'({1'b0, row_ff}) + 14'd1 >= h_ff) begin
                        idx_in = 6'd0;
                        phase_in = PH_TAIL;
                     end else begin
                        olast_in = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     if (idx_ff == 6'd3) begin
                        state_in = ST_OUT;
                     end
                     if (tail_done) begin
                        olast_in = 1'b1;
                        oend_in = 1'b1;
                        started_in = 1'b0;
                        row_in = 13'd0;
                        col_in = 13'd0;
                        comp_in = 2'd0;
                        ctl.crc_init = 1'b1;
                        ctl.adl_init = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
               endcase
            end
         end
         ST_OUT: begin
            // Latch the IDAT CRC once the Adler bytes are folded in.
            if (!sts.busy) begin
               crc_hold_in = sts.crc;
               state_in = ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_HEAD;
         idx_ff <= 6'd0;
         width_reg_ff <= 14'd1;
         height_reg_ff <= 14'd1;
         col_ff <= 13'd0;
         row_ff <= 13'd0;
         comp_ff <= 2'd0;
         started_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         width_reg_ff <= width_reg_in;
         height_reg_ff <= height_reg_in;
         col_ff <= col_in;
         row_ff <= row_in;
         comp_ff <= comp_in;
         started_ff <= started_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      h_ff <= h_in;
      sample_ff <= sample_in;
      len_ff <= len_in;
      crc_hold_ff <= crc_hold_in;
      mcnt_ff <= mcnt_in;
      mcand_ff <= mcand_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      oend_ff <= oend_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_run_last = olast_ff;
   assign rsp_file_end = oend_ff;

endmodule

/* rtl/pngenc_sum.sv */
module pngenc_sum (
   input  logic                     clock,
   input  logic                     reset,
   input  pngenc_pkg::sum_ctl_type  ctl,
   output pngenc_pkg::sum_sts_type  sts
);

   logic [31:0] crc_ff, crc_in;
   logic [3:0]  bits_ff, bits_in;
   logic [15:0] adl_lo_ff, adl_lo_in;
   logic [15:0] adl_hi_ff, adl_hi_in;
   logic        adl_phase_ff, adl_phase_in;
   logic [16:0] lo_sum, hi_sum;

   // The CRC is shifted one bit a cycle; Adler adds a byte into the low sum, then the low sum into the high sum.
   always_comb begin
      crc_in = crc_ff;
      bits_in = bits_ff;
      adl_lo_in = adl_lo_ff;
      adl_hi_in = adl_hi_ff;
      adl_phase_in = 1'b0;
      lo_sum = {1'b0, adl_lo_ff} + {9'd0, ctl.adl_data};
      hi_sum = {1'b0, adl_hi_ff} + {1'b0, adl_lo_ff};
      if (bits_ff != 4'd0) begin
         crc_in = (crc_ff >> 1) ^ (pngenc_pkg::CrcPoly & {32{crc_ff[0]}});
         bits_in = bits_ff - 4'd1;
      end
      if (ctl.crc_init) begin
         crc_in = 32'hFFFFFFFF;
      end else if (ctl.crc_byte) begin
         crc_in = crc_ff ^ {24'd0, ctl.crc_data};
         bits_in = 4'd8;
      end
      if (adl_phase_ff) begin
         adl_hi_in = (hi_sum >= pngenc_pkg::AdlerMod) ?
                     16'(hi_sum - pngenc_pkg::AdlerMod) : hi_sum[15:0];
      end
      if (ctl.adl_init) begin
         adl_lo_in = 16'd1;
         adl_hi_in = 16'd0;
      end else if (ctl.adl_byte) begin
         adl_lo_in = (lo_sum >= pngenc_pkg::AdlerMod) ?
                     16'(lo_sum - pngenc_pkg::AdlerMod) : lo_sum[15:0];
         adl_phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 32'hFFFFFFFF;
         bits_ff <= 4'd0;
         adl_lo_ff <= 16'd1;
         adl_hi_ff <= 16'd0;
         adl_phase_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         bits_ff <= bits_in;
         adl_lo_ff <= adl_lo_in;
         adl_hi_ff <= adl_hi_in;
         adl_phase_ff <= adl_phase_in;
      end
   end

   assign sts.busy = (bits_ff != 4'd0) || adl_phase_ff;
   assign sts.crc = crc_ff ^ 32'hFFFFFFFF;
   assign sts.adler = {adl_hi_ff, adl_lo_ff};

endmodule

/* tb/testbench.sv */
module testbench;

   typedef struct {
      logic [7:0] data;
      logic       run_last;
      logic       file_end;
   } png_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_sample = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_file_end;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = pngenc_pkg::CSR_WIDTH;
   logic [13:0] csr_data = 14'd0;

   png_stored_rgb_encoder_unit dut (.*);

   always #2 clock = ~clock;

   // Shadow of the encoder state.
   logic [13:0] cfg_width = 14'd1;
   logic [13:0] cfg_height = 14'd1;
   logic [31:0] crc_sum;
   int unsigned adler_lo = 1, adler_hi = 0;
   int unsigned col_cnt = 0, row_cnt = 0, comp_cnt = 0;
   bit          in_image = 1'b0;

   logic [7:0]   pending_samples[$];
   png_byte_type expected_bytes[$];
   bit          quiet = 1'b0;
   bit          held = 1'b0;
   int          hold_left = 0;
   int          mismatches = 0;
   int          bytes_checked = 0;
   int          samples_sent = 0;
   int          images_done = 0;

   function automatic int unsigned clamp_dim(input logic [13:0] v, input int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic void crc_feed(input logic [7:0] b);
      crc_sum = crc_sum ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
         crc_sum = (crc_sum >> 1) ^ (crc_sum[0] ? pngenc_pkg::CrcPoly : 32'd0);
   endfunction

   function automatic void emit(input logic [7:0] b, input bit with_crc);
      png_byte_type e;
      e.data = b;
      e.run_last = 1'b0;
      e.file_end = 1'b0;
      expected_bytes.push_back(e);
      if (with_crc) crc_feed(b);
   endfunction

   function automatic void emit32(input logic [31:0] v, input bit with_crc);
      for (int i = 3; i >= 0; i--) emit(v[i*8 +: 8], with_crc);
   endfunction

   function automatic void adler_feed(input logic [7:0] b);
      adler_lo = (adler_lo + b) % pngenc_pkg::AdlerMod;
      adler_hi = (adler_hi + adler_lo) % pngenc_pkg::AdlerMod;
   endfunction

   function automatic void encode_sample(input logic [7:0] s);
      int unsigned w, h;
      logic [31:0] blen;
      w = clamp_dim(cfg_width, pngenc_pkg::MaxWidth);
      h = clamp_dim(cfg_height, pngenc_pkg::MaxHeight);
      if (!in_image) begin
         for (int i = 0; i < 8; i++) emit(pngenc_pkg::signature_byte(i[2:0]), 1'b0);
         emit32(32'd13, 1'b0);
         crc_sum = 32'hFFFFFFFF;
         emit32(32'h49484452, 1'b1);
         emit32(w, 1'b1);
         emit32(h, 1'b1);
         emit(8'h08, 1'b1);
         emit(8'h02, 1'b1);
         emit(8'h00, 1'b1);
         emit(8'h00, 1'b1);
         emit(8'h00, 1'b1);
         emit32(~crc_sum, 1'b0);
         emit32(6 * h + 3 * h * w + 6, 1'b0);
         crc_sum = 32'hFFFFFFFF;
         emit32(32'h49444154, 1'b1);
         emit(8'h78, 1'b1);
         emit(8'h01, 1'b1);
         in_image = 1'b1;
      end
      if (comp_cnt == 0 && col_cnt == 0) begin
         blen = 3 * w + 1;
         emit((row_cnt + 1 == h) ? 8'h01 : 8'h00, 1'b1);
         emit(blen[7:0], 1'b1);
         emit(blen[15:8], 1'b1);
         emit(~blen[7:0], 1'b1);
         emit(~blen[15:8], 1'b1);
         emit(8'h00, 1'b1);
         adler_feed(8'h00);
      end
      emit(s, 1'b1);
      adler_feed(s);
      comp_cnt++;
      if (comp_cnt == 3) begin
         comp_cnt = 0;
         col_cnt++;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
               emit32({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
               emit32(~crc_sum, 1'b0);
               for (int i = 0; i < 12; i++) emit(pngenc_pkg::iend_byte(i[3:0]), 1'b0);
               expected_bytes[expected_bytes.size() - 1].file_end = 1'b1;
               adler_lo = 1;
               adler_hi = 0;
               row_cnt = 0;
               in_image = 1'b0;
               images_done++;
            end
         end
      end
      expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            encode_sample(req_sample);
            void'(pending_samples.pop_front());
            samples_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_samples.size() > 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator.
   always @(posedge clock) begin
      png_byte_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected byte %h", rsp_out_byte);
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_out_byte !== e.data || rsp_run_last !== e.run_last ||
                   rsp_file_end !== e.file_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Byte %0d: expected %h/%b/%b, got %h/%b/%b", bytes_checked,
                              e.data, e.run_last, e.file_end,
                              rsp_out_byte, rsp_run_last, rsp_file_end);
               end
            end
         end
         // Hold off once for a long stretch so the encoder backs up into the request side.
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!held && bytes_checked >= 700) begin
            held <= 1'b1;
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
         end
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() != 0 || expected_bytes.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   task automatic set_size(input logic [13:0] w, input logic [13:0] h);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= pngenc_pkg::CSR_WIDTH;
      csr_data <= w;
      cfg_width = w;
      @(posedge clock);
      csr_index <= pngenc_pkg::CSR_HEIGHT;
      csr_data <= h;
      cfg_height = h;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // pattern 0 random, 1 walks the sample extremes.
   task automatic play_image(input int pattern);
      int n;
      logic [7:0] fixed[8];
      fixed = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
      n = 3 * clamp_dim(cfg_width, pngenc_pkg::MaxWidth) *
          clamp_dim(cfg_height, pngenc_pkg::MaxHeight);
      @(negedge clock);
      for (int i = 0; i < n; i++)
         pending_samples.push_back(pattern ? fixed[i % 8] : 8'($urandom_range(0, 255)));
      wait_idle();
      repeat (4) @(negedge clock);
   endtask

   initial begin
      crc_sum = 32'hFFFFFFFF;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Reset size of one by one, then zero sizes that read as one.
      play_image(1);
      set_size(14'd0, 14'd0);
      play_image(1);
      set_size(14'd2, 14'd3);
      play_image(1);
      while (samples_sent < 320) begin
         set_size(14'($urandom_range(1, 6)), 14'($urandom_range(1, 4)));
         quiet = (images_done == 8);
         play_image(0);
      end
      quiet = 1'b0;
      // A single wider row.
      set_size(14'd5, 14'd1);
      play_image(0);
      set_size(14'd3, 14'd2);
      play_image(0);
      repeat (20) @(posedge clock);
      $display("Encoded %0d images from %0d samples, %0d file bytes checked.",
               images_done, samples_sent, bytes_checked);
      $display("Covered zero dimensions, varied image sizes, sample extremes and a long output stall.");
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(4 * 3_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
